// ----- hw/rtl/obb_separating_axis_test_assert.svh -----
// assertion macros shared by the checkers of the box overlap block
// needs signals named clock and reset in the module that uses them
`ifndef OBB_SEPARATING_AXIS_TEST_ASSERT_SVH
`define OBB_SEPARATING_AXIS_TEST_ASSERT_SVH

// same-cycle implication, off while reset is high
`define OBB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, off while reset is high
`define OBB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- hw/rtl/obb_sat_pkg.sv -----
// shared constants, codes and width helpers of the box overlap block
// no dependencies
`default_nettype none

package obb_sat_pkg;

   localparam int COMP_WIDTH_DEF = 21;
   localparam int ROT_FRAC_DEF   = 19;
   localparam int FIELD_W        = 63;
   localparam int EPS_W          = 19;
   localparam int AXIS_W         = 4;
   localparam int NUM_AXES       = 15;

   // register file
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   typedef logic [CSR_AW-3:0] csr_index_type;
   localparam csr_index_type REG_EPSILON = 1'b0;
   localparam logic [EPS_W-1:0] EPSILON_RESET = EPS_W'(1);

   // result codes, axes numbered in test order
   typedef logic [AXIS_W-1:0] axis_type;
   localparam axis_type AXIS_NONE   = 4'd0;
   localparam axis_type AXIS_AX     = 4'd1;
   localparam axis_type AXIS_BX     = 4'd2;
   localparam axis_type AXIS_AY     = 4'd3;
   localparam axis_type AXIS_AZ     = 4'd4;
   localparam axis_type AXIS_BY     = 4'd5;
   localparam axis_type AXIS_BZ     = 4'd6;
   localparam axis_type AXIS_CROSS0 = 4'd7;

   localparam axis_type FACE_A_AXIS [3] = '{AXIS_AX, AXIS_AY, AXIS_AZ};
   localparam axis_type FACE_B_AXIS [3] = '{AXIS_BX, AXIS_BY, AXIS_BZ};

   // cyclic successor and predecessor of a coordinate index
   localparam int NEXT3 [3] = '{1, 2, 0};
   localparam int PREV3 [3] = '{2, 0, 1};

   // |r| + epsilon
   function automatic int pad_width(input int cw);
      return ((cw > EPS_W) ? cw : EPS_W) + 1;
   endfunction

   // length times padded rotation, signed
   function automatic int prod_width(input int cw);
      return cw + pad_width(cw) + 1;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/obb_sat_front.sv -----
// input register: unpacks the fields and forms the padded absolute rotation
// uses obb_sat_pkg
`default_nettype none

module obb_sat_front #(
   parameter int COMP_WIDTH = obb_sat_pkg::COMP_WIDTH_DEF,
   localparam int PadW = obb_sat_pkg::pad_width(COMP_WIDTH)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_stall,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]     rot_row1,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]     rot_row2,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]     rot_row3,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]     offset,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]     half_a,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]     half_b,
   input  wire logic [obb_sat_pkg::EPS_W-1:0]       epsilon,
   output logic                                     out_valid,
   input  wire logic                                out_stall,
   output logic signed [COMP_WIDTH-1:0]             rot_o [3][3],
   output logic signed [COMP_WIDTH-1:0]             ofs_o [3],
   output logic signed [COMP_WIDTH-1:0]             ha_o  [3],
   output logic signed [COMP_WIDTH-1:0]             hb_o  [3],
   output logic        [PadW-1:0]                   pad_o [3][3]
);
   import obb_sat_pkg::*;

   logic [FIELD_W-1:0]           row_w  [3];
   logic signed [COMP_WIDTH-1:0] rot_in [3][3];
   logic [COMP_WIDTH-1:0]        mag    [3][3];
   logic [PadW-1:0]              pad_in [3][3];
   logic signed [COMP_WIDTH-1:0] ofs_in [3];
   logic signed [COMP_WIDTH-1:0] ha_in  [3];
   logic signed [COMP_WIDTH-1:0] hb_in  [3];

   logic                         valid_ff;
   logic signed [COMP_WIDTH-1:0] rot_ff [3][3];
   logic [PadW-1:0]              pad_ff [3][3];
   logic signed [COMP_WIDTH-1:0] ofs_ff [3];
   logic signed [COMP_WIDTH-1:0] ha_ff  [3];
   logic signed [COMP_WIDTH-1:0] hb_ff  [3];

   assign row_w[0] = rot_row1;
   assign row_w[1] = rot_row2;
   assign row_w[2] = rot_row3;

   always_comb begin
      for (int m = 0; m < 3; m++) begin
         for (int n = 0; n < 3; n++) begin
            rot_in[m][n] = signed'(row_w[m][COMP_WIDTH*n +: COMP_WIDTH]);
            // most negative entry maps onto its exact magnitude
            mag[m][n]    = rot_in[m][n][COMP_WIDTH-1] ? unsigned'(-rot_in[m][n])
                                                      : unsigned'(rot_in[m][n]);
            pad_in[m][n] = PadW'(mag[m][n]) + PadW'(epsilon);
         end
      end
      for (int k = 0; k < 3; k++) begin
         ofs_in[k] = signed'(offset[COMP_WIDTH*k +: COMP_WIDTH]);
         ha_in[k]  = signed'(half_a[COMP_WIDTH*k +: COMP_WIDTH]);
         hb_in[k]  = signed'(half_b[COMP_WIDTH*k +: COMP_WIDTH]);
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         rot_ff <= rot_in;
         pad_ff <= pad_in;
         ofs_ff <= ofs_in;
         ha_ff  <= ha_in;
         hb_ff  <= hb_in;
      end
   end

   assign out_valid = valid_ff;
   assign rot_o     = rot_ff;
   assign pad_o     = pad_ff;
   assign ofs_o     = ofs_ff;
   assign ha_o      = ha_ff;
   assign hb_o      = hb_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/obb_sat_mul.sv -----
// product stage: every length times padded rotation and offset times rotation
// uses obb_sat_pkg
`default_nettype none

module obb_sat_mul #(
   parameter int COMP_WIDTH = obb_sat_pkg::COMP_WIDTH_DEF,
   localparam int PadW  = obb_sat_pkg::pad_width(COMP_WIDTH),
   localparam int ProdW = obb_sat_pkg::prod_width(COMP_WIDTH),
   localparam int TermW = 2 * COMP_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_stall,
   input  wire logic signed [COMP_WIDTH-1:0] rot_i [3][3],
   input  wire logic signed [COMP_WIDTH-1:0] ofs_i [3],
   input  wire logic signed [COMP_WIDTH-1:0] ha_i  [3],
   input  wire logic signed [COMP_WIDTH-1:0] hb_i  [3],
   input  wire logic        [PadW-1:0]       pad_i [3][3],
   output logic                         out_valid,
   input  wire logic                    out_stall,
   output logic signed [ProdW-1:0]      pa_o [3][3][3],
   output logic signed [ProdW-1:0]      pb_o [3][3][3],
   output logic signed [TermW-1:0]      pt_o [3][3][3],
   output logic signed [COMP_WIDTH-1:0] ofs_o [3],
   output logic signed [COMP_WIDTH-1:0] ha_o  [3],
   output logic signed [COMP_WIDTH-1:0] hb_o  [3]
);
   import obb_sat_pkg::*;

   // pa[i][m][n] = a_i * f_mn, pb likewise for box b, pt[i][m][n] = t_i * r_mn
   logic signed [ProdW-1:0]      pa_in [3][3][3];
   logic signed [ProdW-1:0]      pb_in [3][3][3];
   logic signed [TermW-1:0]      pt_in [3][3][3];

   logic                         valid_ff;
   logic signed [ProdW-1:0]      pa_ff [3][3][3];
   logic signed [ProdW-1:0]      pb_ff [3][3][3];
   logic signed [TermW-1:0]      pt_ff [3][3][3];
   logic signed [COMP_WIDTH-1:0] ofs_ff [3];
   logic signed [COMP_WIDTH-1:0] ha_ff  [3];
   logic signed [COMP_WIDTH-1:0] hb_ff  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int m = 0; m < 3; m++) begin
            for (int n = 0; n < 3; n++) begin
               pa_in[i][m][n] = ProdW'(ha_i[i]) * signed'(ProdW'(pad_i[m][n]));
               pb_in[i][m][n] = ProdW'(hb_i[i]) * signed'(ProdW'(pad_i[m][n]));
               pt_in[i][m][n] = TermW'(ofs_i[i]) * TermW'(rot_i[m][n]);
            end
         end
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         pt_ff  <= pt_in;
         ofs_ff <= ofs_i;
         ha_ff  <= ha_i;
         hb_ff  <= hb_i;
      end
   end

   assign out_valid = valid_ff;
   assign pa_o      = pa_ff;
   assign pb_o      = pb_ff;
   assign pt_o      = pt_ff;
   assign ofs_o     = ofs_ff;
   assign ha_o      = ha_ff;
   assign hb_o      = hb_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/obb_sat_cmp.sv -----
// compare stage: projected distance against projected radius on all 15 axes,
// first separating axis into the result register; uses obb_sat_pkg
`default_nettype none

module obb_sat_cmp #(
   parameter int COMP_WIDTH = obb_sat_pkg::COMP_WIDTH_DEF,
   parameter int ROT_FRAC   = obb_sat_pkg::ROT_FRAC_DEF,
   localparam int ProdW = obb_sat_pkg::prod_width(COMP_WIDTH),
   localparam int TermW = 2 * COMP_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_stall,
   input  wire logic signed [ProdW-1:0]      pa_i [3][3][3],
   input  wire logic signed [ProdW-1:0]      pb_i [3][3][3],
   input  wire logic signed [TermW-1:0]      pt_i [3][3][3],
   input  wire logic signed [COMP_WIDTH-1:0] ofs_i [3],
   input  wire logic signed [COMP_WIDTH-1:0] ha_i  [3],
   input  wire logic signed [COMP_WIDTH-1:0] hb_i  [3],
   output logic                         out_valid,
   input  wire logic                    out_stall,
   output obb_sat_pkg::axis_type        axis_o
);
   import obb_sat_pkg::*;

   // four summed products plus sign and abs headroom
   localparam int SumW = ProdW + 3;

   logic signed [SumW-1:0] dist_a [3];
   logic signed [SumW-1:0] rad_a  [3];
   logic signed [SumW-1:0] dist_b [3];
   logic signed [SumW-1:0] rad_b  [3];
   logic signed [SumW-1:0] dist_x [3][3];
   logic signed [SumW-1:0] rad_x  [3][3];
   logic [NUM_AXES-1:0]    sep;
   axis_type               axis_in;

   logic                   valid_ff;
   axis_type               axis_ff;

   function automatic logic signed [SumW-1:0] ext_p(input logic signed [ProdW-1:0] x);
      return SumW'(x);
   endfunction

   function automatic logic signed [SumW-1:0] ext_t(input logic signed [TermW-1:0] x);
      return SumW'(x);
   endfunction

   // length scaled to the rotation's fraction bits
   function automatic logic signed [SumW-1:0] scaled(input logic signed [COMP_WIDTH-1:0] x);
      return SumW'(x) <<< ROT_FRAC;
   endfunction

   function automatic logic signed [SumW-1:0] mag(input logic signed [SumW-1:0] x);
      return x[SumW-1] ? -x : x;
   endfunction

   always_comb begin
      sep = '0;
      for (int i = 0; i < 3; i++) begin
         // face axes of box a
         dist_a[i] = mag(scaled(ofs_i[i]));
         rad_a[i]  = scaled(ha_i[i]) + ext_p(pb_i[0][i][0]) + ext_p(pb_i[1][i][1])
                   + ext_p(pb_i[2][i][2]);
         sep[int'(FACE_A_AXIS[i]) - 1] = dist_a[i] > rad_a[i];
         // face axes of box b, index i is the column here
         dist_b[i] = mag(ext_t(pt_i[0][0][i]) + ext_t(pt_i[1][1][i]) + ext_t(pt_i[2][2][i]));
         rad_b[i]  = scaled(hb_i[i]) + ext_p(pa_i[0][0][i]) + ext_p(pa_i[1][1][i])
                   + ext_p(pa_i[2][2][i]);
         sep[int'(FACE_B_AXIS[i]) - 1] = dist_b[i] > rad_b[i];
      end
      // edge cross products a_i x b_j
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            dist_x[i][j] = mag(ext_t(pt_i[PREV3[i]][NEXT3[i]][j])
                             - ext_t(pt_i[NEXT3[i]][PREV3[i]][j]));
            rad_x[i][j]  = ext_p(pa_i[NEXT3[i]][PREV3[i]][j])
                         + ext_p(pa_i[PREV3[i]][NEXT3[i]][j])
                         + ext_p(pb_i[NEXT3[j]][i][PREV3[j]])
                         + ext_p(pb_i[PREV3[j]][i][NEXT3[j]]);
            sep[int'(AXIS_CROSS0) - 1 + 3*i + j] = dist_x[i][j] > rad_x[i][j];
         end
      end
   end

   // lowest numbered separating axis wins
   always_comb begin
      axis_in = AXIS_NONE;
      for (int k = NUM_AXES - 1; k >= 0; k--) begin
         if (sep[k]) begin
            axis_in = AXIS_W'(k + 1);
         end
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         axis_ff <= axis_in;
      end
   end

   assign out_valid = valid_ff;
   assign axis_o    = axis_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/obb_separating_axis_test.sv -----
// oriented box pair overlap test on 15 separating axes, top level
// holds the epsilon register; uses obb_sat_pkg, obb_sat_front, obb_sat_mul, obb_sat_cmp
//
//  port group  direction  handshake            payload
//  req_*       in         req_valid/req_stall   rotation rows, offset, half extents
//  rsp_*       out        rsp_valid/rsp_stall   separating_axis
//  csr_*       in/out     psel/penable/pready   epsilon at byte address 0
//
// one item per cycle while no stalled result holds the pipeline; a result passes through the
// input register, product register and result register, in that order.
// synchronous reset empties all three stages and sets epsilon to 1.
// a stalled result holds every stage that is full behind it; empty stages
// still take new items, so stall on req_ only rises when all stages are full.
`default_nettype none

module obb_separating_axis_test #(
   parameter int COMP_WIDTH = obb_sat_pkg::COMP_WIDTH_DEF,
   parameter int ROT_FRAC   = obb_sat_pkg::ROT_FRAC_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]      req_rot_row1,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]      req_rot_row2,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]      req_rot_row3,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]      req_offset,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]      req_half_a,
   input  wire logic [obb_sat_pkg::FIELD_W-1:0]      req_half_b,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [obb_sat_pkg::AXIS_W-1:0]            rsp_separating_axis,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [obb_sat_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [obb_sat_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [obb_sat_pkg::CSR_DW-1:0]            csr_prdata,
   output logic                                      csr_pready
);
   import obb_sat_pkg::*;

   localparam int PadW  = pad_width(COMP_WIDTH);
   localparam int ProdW = prod_width(COMP_WIDTH);
   localparam int TermW = 2 * COMP_WIDTH;

   logic [EPS_W-1:0]             eps_ff;
   logic                         csr_write;

   logic                         s1_valid;
   logic                         s1_stall;
   logic signed [COMP_WIDTH-1:0] s1_rot [3][3];
   logic        [PadW-1:0]       s1_pad [3][3];
   logic signed [COMP_WIDTH-1:0] s1_ofs [3];
   logic signed [COMP_WIDTH-1:0] s1_ha  [3];
   logic signed [COMP_WIDTH-1:0] s1_hb  [3];

   logic                         s2_valid;
   logic                         s2_stall;
   logic signed [ProdW-1:0]      s2_pa [3][3][3];
   logic signed [ProdW-1:0]      s2_pb [3][3][3];
   logic signed [TermW-1:0]      s2_pt [3][3][3];
   logic signed [COMP_WIDTH-1:0] s2_ofs [3];
   logic signed [COMP_WIDTH-1:0] s2_ha  [3];
   logic signed [COMP_WIDTH-1:0] s2_hb  [3];

   axis_type                     axis;

   // register file
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DW'(eps_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPSILON_RESET;
      end else if (csr_write && (csr_paddr[CSR_AW-1:2] == REG_EPSILON)) begin
         eps_ff <= csr_pwdata[EPS_W-1:0];
      end
   end

   obb_sat_front #(
      .COMP_WIDTH (COMP_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .rot_row1  (req_rot_row1),
      .rot_row2  (req_rot_row2),
      .rot_row3  (req_rot_row3),
      .offset    (req_offset),
      .half_a    (req_half_a),
      .half_b    (req_half_b),
      .epsilon   (eps_ff),
      .out_valid (s1_valid),
      .out_stall (s1_stall),
      .rot_o     (s1_rot),
      .ofs_o     (s1_ofs),
      .ha_o      (s1_ha),
      .hb_o      (s1_hb),
      .pad_o     (s1_pad)
   );

   obb_sat_mul #(
      .COMP_WIDTH (COMP_WIDTH)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_stall  (s1_stall),
      .rot_i     (s1_rot),
      .ofs_i     (s1_ofs),
      .ha_i      (s1_ha),
      .hb_i      (s1_hb),
      .pad_i     (s1_pad),
      .out_valid (s2_valid),
      .out_stall (s2_stall),
      .pa_o      (s2_pa),
      .pb_o      (s2_pb),
      .pt_o      (s2_pt),
      .ofs_o     (s2_ofs),
      .ha_o      (s2_ha),
      .hb_o      (s2_hb)
   );

   obb_sat_cmp #(
      .COMP_WIDTH (COMP_WIDTH),
      .ROT_FRAC   (ROT_FRAC)
   ) u_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_stall  (s2_stall),
      .pa_i      (s2_pa),
      .pb_i      (s2_pb),
      .pt_i      (s2_pt),
      .ofs_i     (s2_ofs),
      .ha_i      (s2_ha),
      .hb_i      (s2_hb),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .axis_o    (axis)
   );

   assign rsp_separating_axis = axis;

endmodule

`default_nettype wire

// ----- hw/rtl/obb_sat_checker.sv -----
// port-level checks of the box overlap block, bound to its top level
// uses obb_sat_pkg and obb_separating_axis_test_assert.svh
`default_nettype none

`include "obb_separating_axis_test_assert.svh"

module obb_sat_port_checks (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [obb_sat_pkg::AXIS_W-1:0]    rsp_separating_axis
);

   // a held result keeps its word
   `OBB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_separating_axis))

   // input side only backs up when the result side is full and stalled
   `OBB_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

   // with the result side free, an item comes out after three stages
   `OBB_ASSERT_NEXT(a_latency, req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

   // reset leaves the pipeline empty
   `OBB_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid && !req_stall)

endmodule

bind obb_separating_axis_test obb_sat_port_checks u_checker (.*);

`default_nettype wire

// ----- test/obb_sat_checker.sv -----
// watcher for the box overlap block: tracks epsilon writes, predicts the first
// separating axis of every accepted word and compares results in order
// depends on obb_sat_pkg
module obb_sat_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [obb_sat_pkg::FIELD_W-1:0]    req_rot_row1,
   input  logic [obb_sat_pkg::FIELD_W-1:0]    req_rot_row2,
   input  logic [obb_sat_pkg::FIELD_W-1:0]    req_rot_row3,
   input  logic [obb_sat_pkg::FIELD_W-1:0]    req_offset,
   input  logic [obb_sat_pkg::FIELD_W-1:0]    req_half_a,
   input  logic [obb_sat_pkg::FIELD_W-1:0]    req_half_b,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [obb_sat_pkg::AXIS_W-1:0]     rsp_separating_axis,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [obb_sat_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [obb_sat_pkg::CSR_DW-1:0]     csr_pwdata,
   input  logic [obb_sat_pkg::CSR_DW-1:0]     csr_prdata,
   input  logic                               csr_pready,
   output int                                 mismatches,
   output int                                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import obb_sat_pkg::*;

   localparam int    CW      = COMP_WIDTH_DEF;
   localparam longint ROT_ONE = longint'(1) << ROT_FRAC_DEF;

   logic [EPS_W-1:0] epsilon_q = EPSILON_RESET;
   axis_type         pending_axes [$];
   axis_type         want_axis;
   int               fail_count = 0;
   int               pending_count = 0;

   assign mismatches  = fail_count;
   assign outstanding = pending_count;

   function automatic longint field_comp(input logic [FIELD_W-1:0] w, input int idx);
      logic signed [CW-1:0] v;
      v = w[CW*idx +: CW];
      return longint'(v);
   endfunction

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic axis_type first_separating_axis(
      input logic [FIELD_W-1:0] row1, row2, row3, ofs, ha, hb,
      input longint pad
   );
      longint r [3][3];
      longint f [3][3];
      longint t [3];
      longint a [3];
      longint b [3];
      longint s;
      longint radius;
      bit     sep_a [3];
      bit     sep_b [3];
      int     i, j, n, p;
      for (j = 0; j < 3; j++) begin
         r[0][j] = field_comp(row1, j);
         r[1][j] = field_comp(row2, j);
         r[2][j] = field_comp(row3, j);
         t[j]    = field_comp(ofs, j);
         a[j]    = field_comp(ha, j);
         b[j]    = field_comp(hb, j);
      end
      for (i = 0; i < 3; i++)
         for (j = 0; j < 3; j++)
            f[i][j] = mag(r[i][j]) + pad;
      // face axes of A, lengths scaled by one so the compare stays exact
      for (i = 0; i < 3; i++) begin
         radius = a[i] * ROT_ONE + b[0] * f[i][0] + b[1] * f[i][1] + b[2] * f[i][2];
         sep_a[i] = mag(t[i]) * ROT_ONE > radius;
      end
      for (j = 0; j < 3; j++) begin
         s = t[0] * r[0][j] + t[1] * r[1][j] + t[2] * r[2][j];
         radius = b[j] * ROT_ONE + a[0] * f[0][j] + a[1] * f[1][j] + a[2] * f[2][j];
         sep_b[j] = mag(s) > radius;
      end
      if (sep_a[0]) return AXIS_AX;
      if (sep_b[0]) return AXIS_BX;
      if (sep_a[1]) return AXIS_AY;
      if (sep_a[2]) return AXIS_AZ;
      if (sep_b[1]) return AXIS_BY;
      if (sep_b[2]) return AXIS_BZ;
      // edge-edge axes, A axis outer and B axis inner
      for (i = 0; i < 3; i++) begin
         n = (i + 1) % 3;
         p = (i + 2) % 3;
         for (j = 0; j < 3; j++) begin
            s = t[p] * r[n][j] - t[n] * r[p][j];
            radius = a[n] * f[p][j] + a[p] * f[n][j]
                   + b[(j + 1) % 3] * f[i][(j + 2) % 3]
                   + b[(j + 2) % 3] * f[i][(j + 1) % 3];
            if (mag(s) > radius) return axis_type'(AXIS_CROSS0 + 3 * i + j);
         end
      end
      return AXIS_NONE;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending_axes.delete();
         epsilon_q = EPSILON_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_AW-1:2] == REG_EPSILON) begin
            if (csr_pwrite) begin
               epsilon_q = csr_pwdata[EPS_W-1:0];
            end else if (csr_prdata !== CSR_DW'(epsilon_q)) begin
               $display("%0t: epsilon read expected %0d, got %0d",
                        $time, epsilon_q, csr_prdata);
               fail_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_axes.size() == 0) begin
               $display("%0t: separating axis expected none, got %0d",
                        $time, rsp_separating_axis);
               fail_count++;
            end else begin
               want_axis = pending_axes.pop_front();
               if (rsp_separating_axis !== want_axis) begin
                  $display("%0t: separating axis expected %0d, got %0d",
                           $time, want_axis, rsp_separating_axis);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_axes.insert(pending_axes.size(), first_separating_axis(req_rot_row1,
               req_rot_row2, req_rot_row3, req_offset, req_half_a, req_half_b,
               longint'(epsilon_q)));
      end
      pending_count = pending_axes.size();
   end

endmodule

// ----- test/tb.sv -----
// top of the box overlap testbench: clock, reset, epsilon writes, box pair words
// with bursty sending and patterned result stalls; checking lives in obb_sat_checker
// depends on obb_sat_pkg, obb_sat_checker and the obb_separating_axis_test RTL
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import obb_sat_pkg::*;

   localparam int CW      = COMP_WIDTH_DEF;
   localparam int ROT_ONE = 1 << ROT_FRAC_DEF;
   localparam int LEN_MAX = (1 << (CW - 1)) - 1;
   localparam int LEN_MIN = -(1 << (CW - 1));
   localparam int EPS_MAX = (1 << EPS_W) - 1;
   localparam int K       = 1024;   // 1.0 in Q10.10

   typedef struct packed {
      logic [FIELD_W-1:0] rot_row1;
      logic [FIELD_W-1:0] rot_row2;
      logic [FIELD_W-1:0] rot_row3;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] half_a;
      logic [FIELD_W-1:0] half_b;
   } box_pair_type;

   typedef enum {STALL_NEVER, STALL_RANDOM, STALL_PERIODIC, STALL_BURSTY} stall_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [FIELD_W-1:0] req_rot_row1 = '0;
   logic [FIELD_W-1:0] req_rot_row2 = '0;
   logic [FIELD_W-1:0] req_rot_row3 = '0;
   logic [FIELD_W-1:0] req_offset = '0;
   logic [FIELD_W-1:0] req_half_a = '0;
   logic [FIELD_W-1:0] req_half_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [AXIS_W-1:0]  rsp_separating_axis;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr = '0;
   logic [CSR_DW-1:0]  csr_pwdata = '0;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;
   int                 mismatches;
   int                 outstanding;

   stall_style_type    stall_style = STALL_RANDOM;
   int                 stall_tick = 0;
   int                 stall_run = 0;

   obb_separating_axis_test u_top (.*);

   obb_sat_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   always @(negedge clock) begin
      case (stall_style)
         STALL_NEVER: begin
            rsp_stall <= 1'b0;
         end
         STALL_RANDOM: begin
            rsp_stall <= ($urandom_range(0, 99) < 40);
         end
         STALL_PERIODIC: begin
            stall_tick <= stall_tick + 1;
            rsp_stall <= (stall_tick % 5) >= 3;
         end
         default: begin
            // long runs of stall and no stall
            if (stall_run == 0) begin
               stall_run <= $urandom_range(1, 12);
               rsp_stall <= ~rsp_stall;
            end else begin
               stall_run <= stall_run - 1;
            end
         end
      endcase
   end

   function automatic logic [FIELD_W-1:0] pack3(input int c0, input int c1, input int c2);
      return {c2[CW-1:0], c1[CW-1:0], c0[CW-1:0]};
   endfunction

   function automatic box_pair_type uniform_pair(input logic [FIELD_W-1:0] w);
      return '{w, w, w, w, w, w};
   endfunction

   // unit rotation, or B's axes taken as A's y, z, x
   function automatic box_pair_type aligned_pair(input bit permuted,
      input int tx, input int ty, input int tz,
      input int ax, input int ay, input int az,
      input int bx, input int by, input int bz);
      box_pair_type bp;
      if (permuted) begin
         bp.rot_row1 = pack3(0, 0, ROT_ONE);
         bp.rot_row2 = pack3(ROT_ONE, 0, 0);
         bp.rot_row3 = pack3(0, ROT_ONE, 0);
      end else begin
         bp.rot_row1 = pack3(ROT_ONE, 0, 0);
         bp.rot_row2 = pack3(0, ROT_ONE, 0);
         bp.rot_row3 = pack3(0, 0, ROT_ONE);
      end
      bp.offset = pack3(tx, ty, tz);
      bp.half_a = pack3(ax, ay, az);
      bp.half_b = pack3(bx, by, bz);
      return bp;
   endfunction

   function automatic box_pair_type random_box_pair();
      box_pair_type bp;
      logic [383:0] noise;
      int rot [9];
      int t [3];
      int a [3];
      int b [3];
      int kind, span, k;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         for (k = 0; k < 12; k++) noise[32*k +: 32] = $urandom;
         bp = noise[$bits(box_pair_type)-1:0];
         return bp;
      end
      span = 1 << $urandom_range(2, 18);
      for (k = 0; k < 9; k++) begin
         if (kind < 35) begin
            case ($urandom_range(0, 3))
               0: rot[k] = 0;
               1: rot[k] = ROT_ONE;
               2: rot[k] = -ROT_ONE;
               default: rot[k] = int'($urandom_range(0, 2048)) - 1024;
            endcase
         end else begin
            rot[k] = int'($urandom_range(0, 2 * ROT_ONE)) - ROT_ONE;
         end
      end
      for (k = 0; k < 3; k++) begin
         a[k] = $urandom_range(0, span);
         b[k] = $urandom_range(0, span);
         if ($urandom_range(0, 19) == 0) a[k] = -a[k];
         if ($urandom_range(0, 19) == 0) b[k] = -b[k];
         t[k] = $urandom_range(0, 3 * span);
         if ($urandom_range(0, 1)) t[k] = -t[k];
      end
      bp.rot_row1 = pack3(rot[0], rot[1], rot[2]);
      bp.rot_row2 = pack3(rot[3], rot[4], rot[5]);
      bp.rot_row3 = pack3(rot[6], rot[7], rot[8]);
      bp.offset   = pack3(t[0], t[1], t[2]);
      bp.half_a   = pack3(a[0], a[1], a[2]);
      bp.half_b   = pack3(b[0], b[1], b[2]);
      return bp;
   endfunction

   task automatic csr_access(input logic write_en, input csr_index_type idx,
                             input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_pair(input box_pair_type bp);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_rot_row1 <= bp.rot_row1;
      req_rot_row2 <= bp.rot_row2;
      req_rot_row3 <= bp.rot_row3;
      req_offset   <= bp.offset;
      req_half_a   <= bp.half_a;
      req_half_b   <= bp.half_b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic hold_off(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic run_random(input int count, input bit gaps);
      int burst_left;
      int i;
      burst_left = $urandom_range(1, 24);
      for (i = 0; i < count; i++) begin
         if (gaps && burst_left == 0) begin
            hold_off(($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
         end
         send_pair(random_box_pair());
         burst_left--;
      end
   endtask

   initial begin
      int               phase;
      logic [31:0]      eps;
      stall_style_type  style;
      bit               gaps;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_access(1'b0, REG_EPSILON, '0);

      send_pair(uniform_pair('0));
      send_pair(uniform_pair('1));
      send_pair(uniform_pair(pack3(LEN_MAX, LEN_MAX, LEN_MAX)));
      send_pair(uniform_pair(pack3(LEN_MIN, LEN_MIN, LEN_MIN)));
      send_pair(uniform_pair(FIELD_W'({FIELD_W/2+1{2'b01}})));
      send_pair(uniform_pair(FIELD_W'({FIELD_W/2+1{2'b10}})));
      send_pair(aligned_pair(1'b0, 0, 0, 0, K, K, K, K, K, K));
      send_pair(aligned_pair(1'b0, 3*K, 0, 0, K, K, K, K, K, K));
      send_pair(aligned_pair(1'b0, -3*K, 0, 0, K, K, K, K, K, K));
      send_pair(aligned_pair(1'b0, 0, 3*K, 0, K, K, K, K, K, K));
      send_pair(aligned_pair(1'b0, 0, 0, 3*K, K, K, K, K, K, K));
      send_pair(aligned_pair(1'b1, 0, 3*K, 0, K, K, K, K, K, K));
      // wide B flanks make the A face tests pass so a B face test decides
      send_pair(aligned_pair(1'b1, 0, 0, 2*K+1, K, K, K, LEN_MAX, K, LEN_MAX));
      send_pair(aligned_pair(1'b1, 2*K+1, 0, 0, K, K, K, LEN_MAX, LEN_MAX, K));
      // distance exactly equal to the radius on A's x axis, then one past it
      send_pair(aligned_pair(1'b0, 2*K+1, 0, 0, K, K, K, K, ROT_ONE-K, 0));
      send_pair(aligned_pair(1'b0, 2*K+2, 0, 0, K, K, K, K, ROT_ONE-K, 0));
      // negative half extents
      send_pair(aligned_pair(1'b0, 0, 0, 0, -K, -K, -K, 0, 0, 0));
      send_pair(aligned_pair(1'b0, 0, 0, 0, 4*K, 4*K, 4*K, -K, -K, -K));

      for (phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: begin
               eps = 0; style = STALL_RANDOM; gaps = 1'b1;
            end
            1: begin
               eps = EPS_MAX; style = STALL_NEVER; gaps = 1'b0;
            end
            2: begin
               eps = $urandom_range(0, EPS_MAX); style = STALL_PERIODIC; gaps = 1'b1;
            end
            3: begin
               eps = $urandom_range(0, 64); style = STALL_BURSTY; gaps = 1'b1;
            end
            default: begin
               eps = CSR_DW'(EPSILON_RESET); style = STALL_RANDOM; gaps = 1'b0;
            end
         endcase
         csr_access(1'b1, REG_EPSILON, eps);
         csr_access(1'b0, REG_EPSILON, '0);
         stall_style <= style;
         run_random(280, gaps);
      end

      drain();
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
